/* src/rar_pkg.sv */
// rar_pkg: shared types and codes for the region arena allocator
// no dependencies; imported by rar_plist, region_arena_allocator_core, rar_checker and tb_top
package rar_pkg;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_REWIND  = 2'd2;

    localparam logic [1:0] PATH_HEAD    = 2'd0;
    localparam logic [1:0] PATH_PARTIAL = 2'd1;
    localparam logic [1:0] PATH_CACHED  = 2'd2;
    localparam logic [1:0] PATH_LARGE   = 2'd3;

    localparam logic [1:0] CFG_REGION_BYTES = 2'd0;
    localparam logic [1:0] CFG_LOW_WMARK    = 2'd1;
    localparam logic [1:0] CFG_SWAP         = 2'd2;

    localparam int CFG_W  = 21;
    localparam int SIZE_W = 32;

    // partial list control
    typedef struct packed {
        logic clear;
        logic push;
        logic remove;
    } t_plist_ctl;

endpackage

/* src/region_arena_allocator_core.sv */
// region_arena_allocator_core: top level, request sequencer over slot memory
// depends on rar_pkg, rar_slot_mem, rar_plist
//
// channel   direction  handshake                    payload
// request   in         i_start & !o_busy            i_kind, i_size
// result    out        o_done (one cycle strobe)    o_granted, o_slot, o_offset, o_path
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// events answer in the cycle after accept; head hits go through ST_HEAD first.
// a partial list probe goes through ST_SRD and ST_SCHK per entry and a fresh slot
// scan checks one slot per ST_SCAN step; the slot memory read port is registered.
// after reset the ST_INIT state writes the head entry, busy stays high meanwhile.
// results cannot be stalled; a new request may start the cycle its result shows.
module region_arena_allocator_core #(
    parameter int REGION_SLOTS = 16,
    parameter int HEADER_BYTES = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  logic [1:0]   i_kind,
    input  logic [31:0]  i_size,
    output logic         o_done,
    output logic         o_granted,
    output logic [3:0]   o_slot,
    output logic [31:0]  o_offset,
    output logic [1:0]   o_path,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [20:0]  i_cfg_data
);
    import rar_pkg::*;

    localparam int SW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_HEAD = 3'd2;
    localparam logic [2:0] ST_SRD  = 3'd3;
    localparam logic [2:0] ST_SCHK = 3'd4;
    localparam logic [2:0] ST_SCAN = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_region_bytes, r_low_wmark;
    logic              r_swap;
    logic [REGION_SLOTS-1:0] r_in_use, n_in_use, r_cached, n_cached;
    logic [SW-1:0]     r_head, n_head;
    logic              r_ext, n_ext;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_head_rem, n_head_rem;
    logic [CW-1:0]     r_idx, n_idx;
    logic [SW-1:0]     r_cur, n_cur;
    logic [SW-1:0]     r_scan, n_scan;
    logic              r_done, n_done, r_granted, n_granted;
    logic [SW-1:0]     r_slot, n_slot;
    logic [31:0]       r_offset, n_offset;
    logic [1:0]        r_path, n_path;

    logic              rd_en, we;
    logic [SW-1:0]     rd_addr, wr_addr;
    logic [31:0]       rd_rem, rd_off, wr_rem, wr_off;
    t_plist_ctl        pl_ctl;
    logic [SW-1:0]     pl_push_val, pl_rd;
    logic [CW-1:0]     pl_count;

    logic [31:0]       head_cap, new_rem, wmark32;
    logic [32:0]       nbytes;
    logic              fits_cached, do_swap;

    rar_slot_mem #(.SLOTS(REGION_SLOTS), .SW(SW)) u_mem (
        .i_clk(i_clk), .i_rd_en(rd_en), .i_rd_addr(rd_addr),
        .o_rd_rem(rd_rem), .o_rd_off(rd_off), .i_we(we), .i_wr_addr(wr_addr),
        .i_wr_rem(wr_rem), .i_wr_off(wr_off)
    );

    rar_plist #(.SLOTS(REGION_SLOTS), .SW(SW), .CW(CW)) u_plist (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(pl_ctl), .i_push_val(pl_push_val),
        .i_idx(r_idx), .o_rd_val(pl_rd), .o_count(pl_count)
    );

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_bytes <= CFG_W'(4096);
            r_low_wmark    <= CFG_W'(64);
            r_swap         <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REGION_BYTES: r_region_bytes <= i_cfg_data;
                CFG_LOW_WMARK:    r_low_wmark    <= i_cfg_data;
                CFG_SWAP:         r_swap         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // derived arithmetic
    assign head_cap = (32'(r_region_bytes) > HDR) ? 32'(r_region_bytes) - HDR : 32'd0;
    assign wmark32  = 32'(r_low_wmark);
    assign nbytes   = {1'b0, r_size} + 33'(HEADER_BYTES);
    assign fits_cached = nbytes <= 33'(r_region_bytes);
    assign new_rem  = 32'(33'(r_region_bytes) - nbytes);
    assign do_swap  = r_swap && (new_rem > r_head_rem);

    // sequencer
    always_comb begin
        n_state = r_state; n_in_use = r_in_use; n_cached = r_cached; n_head = r_head;
        n_ext = r_ext; n_size = r_size; n_head_rem = r_head_rem; n_idx = r_idx;
        n_cur = r_cur; n_scan = r_scan; n_done = 1'b0; n_granted = r_granted;
        n_slot = r_slot; n_offset = r_offset; n_path = r_path;
        rd_en = 1'b0; rd_addr = r_head; we = 1'b0; wr_addr = r_head;
        wr_rem = head_cap; wr_off = HDR;
        pl_ctl = '0; pl_push_val = r_scan;
        unique case (r_state)
            ST_INIT: begin
                we = 1'b1;
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_size = i_size;
                    n_granted = 1'b1; n_slot = r_head; n_offset = '0; n_path = PATH_HEAD;
                    case (i_kind)
                        KIND_ALLOC: begin
                            rd_en = 1'b1;
                            n_state = ST_HEAD;
                        end
                        KIND_RELEASE: begin
                            n_in_use = r_in_use & (REGION_SLOTS'(1) << r_head);
                            n_cached = r_cached & (REGION_SLOTS'(1) << r_head);
                            pl_ctl.clear = 1'b1;
                            n_ext = 1'b0;
                            n_done = 1'b1;
                        end
                        KIND_REWIND: begin
                            we = 1'b1;
                            n_done = 1'b1;
                        end
                        default: begin
                            n_granted = 1'b0; n_slot = '0;
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_HEAD: begin
                n_head_rem = rd_rem;
                n_idx = '0; n_scan = '0;
                if (r_size <= rd_rem) begin
                    we = 1'b1; wr_rem = rd_rem - r_size; wr_off = rd_off + r_size;
                    n_offset = rd_off; n_done = 1'b1;
                    n_state = ST_IDLE;
                end else if (!r_ext) begin
                    n_ext = 1'b1;
                    pl_ctl.clear = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_SRD: begin
                if (r_idx >= pl_count) begin
                    n_state = ST_SCAN;
                end else begin
                    rd_en = 1'b1; rd_addr = pl_rd; n_cur = pl_rd;
                    n_state = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if (r_size <= rd_rem) begin
                    we = 1'b1; wr_addr = r_cur;
                    wr_rem = rd_rem - r_size; wr_off = rd_off + r_size;
                    pl_ctl.remove = (rd_rem - r_size) < wmark32;
                    n_slot = r_cur; n_offset = rd_off; n_path = PATH_PARTIAL;
                    n_done = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_SRD;
                end
            end
            ST_SCAN: begin
                if (!r_in_use[r_scan]) begin
                    we = 1'b1; wr_addr = r_scan; wr_off = HDR + r_size;
                    n_in_use[r_scan] = 1'b1;
                    n_cached[r_scan] = fits_cached;
                    n_slot = r_scan; n_offset = HDR; n_done = 1'b1;
                    n_state = ST_IDLE;
                    if (fits_cached) begin
                        wr_rem = new_rem; n_path = PATH_CACHED;
                        if (do_swap) begin
                            pl_push_val = r_head;
                            pl_ctl.push = r_head_rem >= wmark32;
                            n_head = r_scan;
                        end else begin
                            pl_ctl.push = new_rem >= wmark32;
                        end
                    end else begin
                        wr_rem = '0; n_path = PATH_LARGE;
                    end
                end else if (r_scan == SW'(REGION_SLOTS - 1)) begin
                    n_granted = 1'b0; n_slot = '0; n_offset = '0; n_path = PATH_HEAD;
                    n_done = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_in_use <= REGION_SLOTS'(1);
            r_cached <= REGION_SLOTS'(1);
            r_head   <= '0;
            r_ext    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_use <= n_in_use;
            r_cached <= n_cached;
            r_head   <= n_head;
            r_ext    <= n_ext;
            r_done   <= n_done;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_size <= n_size; r_head_rem <= n_head_rem; r_idx <= n_idx; r_cur <= n_cur;
        r_scan <= n_scan; r_granted <= n_granted; r_slot <= n_slot;
        r_offset <= n_offset; r_path <= n_path;
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_done    = r_done;
    assign o_granted = r_granted;
    assign o_slot    = 4'(r_slot);
    assign o_offset  = r_offset;
    assign o_path    = r_path;

`ifndef SYNTH
    a_head_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use[r_head]) else $error("head slot not in use");
    a_head_cached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cached[r_head]) else $error("head slot not cached");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pl_count <= CW'(REGION_SLOTS)) else $error("partial count overflow");
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state != ST_INIT)) else $error("result without request");
`endif
endmodule

/* src/rar_slot_mem.sv */
// rar_slot_mem: per-slot remaining bytes and next offset, registered read
// no dependencies
module rar_slot_mem #(
    parameter int SLOTS = 16,
    parameter int SW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [SW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_rem,
    output logic [31:0]   o_rd_off,
    input  logic          i_we,
    input  logic [SW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_rem,
    input  logic [31:0]   i_wr_off
);
    logic [63:0] r_mem [SLOTS];
    logic [63:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= {i_wr_rem, i_wr_off};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_rem = r_rd[63:32];
    assign o_rd_off = r_rd[31:0];
endmodule

/* src/rar_plist.sv */
// rar_plist: most-recent-first list of partly used slots
// depends on rar_pkg
module rar_plist #(
    parameter int SLOTS = 16,
    parameter int SW    = 4,
    parameter int CW    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rar_pkg::t_plist_ctl i_ctl,
    input  logic [SW-1:0]       i_push_val,
    input  logic [CW-1:0]       i_idx,
    output logic [SW-1:0]       o_rd_val,
    output logic [CW-1:0]       o_count
);
    import rar_pkg::*;

    logic [SW-1:0] r_list [SLOTS];
    logic [CW-1:0] r_count;

    // entry shifting: push moves up, remove closes the gap
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SLOTS; j++) begin
            if (i_ctl.push) begin
                r_list[j] <= (j == 0) ? i_push_val : r_list[(j == 0) ? 0 : j - 1];
            end else if (i_ctl.remove && (CW'(j) >= i_idx) && (j + 1 < SLOTS)) begin
                r_list[j] <= r_list[(j + 1 < SLOTS) ? j + 1 : j];
            end
        end
    end

    // fill count, saturating at capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.push) begin
            if (r_count != CW'(SLOTS)) begin
                r_count <= r_count + 1'b1;
            end
        end else if (i_ctl.remove) begin
            r_count <= r_count - 1'b1;
        end
    end

    assign o_rd_val = r_list[i_idx[SW-1:0]];
    assign o_count  = r_count;
endmodule

/* tb/rar_checker.sv */
// rar_checker: watches the request, result and config channels of the allocator,
// predicts every result from its own copy of the slot table and compares in order
// depends on rar_pkg
module rar_checker
    import rar_pkg::*;
#(
    parameter int REGION_SLOTS = 16,
    parameter int HEADER_BYTES = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_busy,
    input  logic [1:0]   i_kind,
    input  logic [31:0]  i_size,
    input  logic         i_done,
    input  logic         i_granted,
    input  logic [3:0]   i_slot,
    input  logic [31:0]  i_offset,
    input  logic [1:0]   i_path,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [20:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        granted;
        logic [3:0]  slot;
        logic [31:0] offset;
        logic [1:0]  path;
    } t_grant;

    t_grant grant_q[$];

    // shadow configuration
    logic [CFG_W-1:0] region_bytes;
    logic [CFG_W-1:0] low_wmark;
    logic             swap_en;

    // shadow slot table
    logic [31:0] remaining [REGION_SLOTS];
    logic [31:0] next_off  [REGION_SLOTS];
    logic        in_use    [REGION_SLOTS];
    logic        cached    [REGION_SLOTS];
    logic [3:0]  plist     [REGION_SLOTS];
    int          plist_cnt;
    logic [3:0]  head;
    logic        extended;

    int fails;
    assign o_fail_count = fails;
    assign o_pending    = grant_q.size();

    function automatic logic [31:0] head_cap();
        return (region_bytes > HEADER_BYTES) ? 32'(region_bytes) - HEADER_BYTES : 32'd0;
    endfunction

    function automatic void table_reset();
        region_bytes = 21'd4096;
        low_wmark    = 21'd64;
        swap_en      = 1'b0;
        for (int i = 0; i < REGION_SLOTS; i++) begin
            remaining[i] = '0;
            next_off[i]  = HEADER_BYTES;
            in_use[i]    = 1'b0;
            cached[i]    = 1'b0;
            plist[i]     = '0;
        end
        plist_cnt = 0;
        head      = '0;
        extended  = 1'b0;
        in_use[0] = 1'b1;
        cached[0] = 1'b1;
        remaining[0] = head_cap();
        next_off[0]  = HEADER_BYTES;
    endfunction

    function automatic logic [31:0] bump_slot(logic [3:0] s, logic [31:0] size);
        logic [31:0] at;
        at = next_off[s];
        remaining[s] = remaining[s] - size;
        next_off[s]  = at + size;
        return at;
    endfunction

    // most recent first; a full list drops its oldest entry
    function automatic void plist_push(logic [3:0] s);
        int i;
        i = (plist_cnt < REGION_SLOTS) ? plist_cnt : REGION_SLOTS - 1;
        for (; i > 0; i--) plist[i] = plist[i-1];
        plist[0] = s;
        if (plist_cnt < REGION_SLOTS) plist_cnt++;
    endfunction

    function automatic void plist_remove(int idx);
        for (int i = idx; i + 1 < plist_cnt; i++) plist[i] = plist[i+1];
        plist_cnt--;
    endfunction

    function automatic t_grant serve_alloc(logic [31:0] size);
        t_grant      g;
        logic [3:0]  s;
        logic [3:0]  keep;
        logic [63:0] nbytes;
        int          free_idx;
        g = '0;
        // head bump
        if (size <= remaining[head]) begin
            g.offset  = bump_slot(head, size);
            g.granted = 1'b1;
            g.slot    = head;
            g.path    = PATH_HEAD;
            return g;
        end
        // first miss starts an empty partly used list
        if (!extended) begin
            extended  = 1'b1;
            plist_cnt = 0;
        end else begin
            for (int i = 0; i < plist_cnt && i < REGION_SLOTS; i++) begin
                s = plist[i];
                if (size <= remaining[s]) begin
                    g.offset = bump_slot(s, size);
                    if (remaining[s] < 32'(low_wmark)) plist_remove(i);
                    g.granted = 1'b1;
                    g.slot    = s;
                    g.path    = PATH_PARTIAL;
                    return g;
                end
            end
        end
        // lowest free slot
        free_idx = REGION_SLOTS;
        for (int i = REGION_SLOTS - 1; i >= 0; i--)
            if (!in_use[i]) free_idx = i;
        if (free_idx >= REGION_SLOTS) return g;
        s = 4'(free_idx);
        in_use[s]   = 1'b1;
        next_off[s] = HEADER_BYTES + size;
        nbytes = 64'(size) + HEADER_BYTES;
        g.granted = 1'b1;
        g.slot    = s;
        g.offset  = HEADER_BYTES;
        if (nbytes <= 64'(region_bytes)) begin
            cached[s]    = 1'b1;
            remaining[s] = 32'(64'(region_bytes) - nbytes);
            keep = s;
            if (swap_en && remaining[s] > remaining[head]) begin
                keep = head;
                head = s;
            end
            if (remaining[keep] >= 32'(low_wmark)) plist_push(keep);
            g.path = PATH_CACHED;
        end else begin
            cached[s]    = 1'b0;
            remaining[s] = '0;
            g.path = PATH_LARGE;
        end
        return g;
    endfunction

    function automatic t_grant predict(logic [1:0] kind, logic [31:0] size);
        t_grant g;
        g = '0;
        case (kind)
            KIND_ALLOC: g = serve_alloc(size);
            KIND_RELEASE: begin
                for (int i = 0; i < REGION_SLOTS; i++) begin
                    if (4'(i) != head) begin
                        in_use[i]    = 1'b0;
                        cached[i]    = 1'b0;
                        remaining[i] = '0;
                    end
                end
                plist_cnt = 0;
                extended  = 1'b0;
                g.granted = 1'b1;
                g.slot    = head;
            end
            KIND_REWIND: begin
                remaining[head] = head_cap();
                next_off[head]  = HEADER_BYTES;
                g.granted = 1'b1;
                g.slot    = head;
            end
            default: g = '0;
        endcase
        return g;
    endfunction

    initial begin
        fails = 0;
        table_reset();
    end

    always @(posedge i_clk) begin
        t_grant exp_g;
        if (!i_rst_n) begin
            table_reset();
        end else begin
            // compare result against oldest prediction
            if (i_done) begin
                if (grant_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    exp_g = grant_q.pop_front();
                    if (i_granted !== exp_g.granted) begin
                        $error("granted: expected %0d actual %0d", exp_g.granted, i_granted);
                        fails++;
                    end
                    if (i_slot !== exp_g.slot) begin
                        $error("slot: expected %0d actual %0d", exp_g.slot, i_slot);
                        fails++;
                    end
                    if (i_offset !== exp_g.offset) begin
                        $error("offset: expected %0h actual %0h", exp_g.offset, i_offset);
                        fails++;
                    end
                    if (i_path !== exp_g.path) begin
                        $error("path: expected %0d actual %0d", exp_g.path, i_path);
                        fails++;
                    end
                end
            end
            // accepted request
            if (i_start && !i_busy) grant_q.push_back(predict(i_kind, i_size));
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REGION_BYTES: region_bytes = i_cfg_data;
                    CFG_LOW_WMARK:    low_wmark    = i_cfg_data;
                    CFG_SWAP:         swap_en      = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for region_arena_allocator_core
// depends on rar_pkg, region_arena_allocator_core and rar_checker
module tb_top;
    import rar_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_start = 1'b0;
    logic [1:0]   i_kind = KIND_ALLOC;
    logic [31:0]  i_size = '0;
    logic         i_cfg_valid = 1'b0;
    logic [1:0]   i_cfg_index = CFG_REGION_BYTES;
    logic [20:0]  i_cfg_data = '0;
    logic         o_busy, o_done, o_granted, o_cfg_ready;
    logic [3:0]   o_slot;
    logic [31:0]  o_offset;
    logic [1:0]   o_path;
    int           fail_count, pending;
    int           cycles = 0;
    int           region_now = 4096;

    region_arena_allocator_core dut (.*);

    rar_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_size,
        .i_done(o_done), .i_granted(o_granted), .i_slot(o_slot), .i_offset(o_offset),
        .i_path(o_path), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one request, with a random hold-off first
    task automatic send_req(logic [1:0] kind, logic [31:0] size);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind  <= kind;
        i_size  <= size;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [20:0] data);
        wait_idle();
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_REGION_BYTES) region_now = data;
    endtask

    task automatic set_config(logic [20:0] rb, logic [20:0] wm, logic sw);
        write_reg(CFG_REGION_BYTES, rb);
        write_reg(CFG_LOW_WMARK, wm);
        write_reg(CFG_SWAP, {20'd0, sw});
    endtask

    // random size shaped around the current region size
    function automatic logic [31:0] pick_size();
        int c;
        c = $urandom_range(0, 99);
        if (c < 55) return $urandom_range(0, (region_now / 8) + 1);
        if (c < 85) return $urandom_range(0, region_now);
        if (c < 93) return $urandom_range(region_now, region_now * 2 + 64);
        return $urandom();
    endfunction

    task automatic random_phase(int n);
        int c;
        for (int k = 0; k < n; k++) begin
            c = $urandom_range(0, 99);
            if (c < 86)      send_req(KIND_ALLOC, pick_size());
            else if (c < 92) send_req(KIND_RELEASE, $urandom());
            else if (c < 98) send_req(KIND_REWIND, $urandom());
            else             send_req(2'd3, $urandom());
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: head fit extremes, first miss, large region, events, unknown kind
        send_req(KIND_ALLOC, 32'd0);
        send_req(KIND_ALLOC, 32'd4064 - 32'd0);
        send_req(KIND_ALLOC, 32'd1);
        send_req(KIND_ALLOC, 32'hFFFF_FFFF);
        send_req(KIND_ALLOC, 32'd100);
        send_req(KIND_ALLOC, 32'd3000);
        send_req(2'd3, 32'hFFFF_FFFF);
        send_req(KIND_REWIND, 32'd0);
        send_req(KIND_RELEASE, 32'd0);
        // exhaust every slot so a request is refused
        for (int k = 0; k < 17; k++) send_req(KIND_ALLOC, 32'd4000);

        // phases over several settings, extremes among them
        random_phase(300);
        set_config(21'd64, 21'd0, 1'b1);
        random_phase(300);
        set_config(21'd1048576, 21'd1048576, 1'b0);
        random_phase(250);
        set_config(21'h1FFFFF, 21'h1FFFFF, 1'b1);
        random_phase(200);
        set_config(21'd20, 21'd8, 1'b1);
        random_phase(60);
        write_reg(2'd3, 21'h1FFFFF);
        set_config(21'd1000, 21'd100, 1'b1);
        random_phase(400);
        set_config(21'd8192, 21'd64, 1'b0);
        random_phase(370);

        wait_idle();
        repeat (80) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/rar_pkg.sv
src/rar_slot_mem.sv
src/rar_plist.sv
src/region_arena_allocator_core.sv
tb/rar_checker.sv
tb/tb_top.sv
